/* rtl/core/befp_pkg.sv */
// befp_pkg: shared types, codes and constants for the binary event frame parser
// used by every module in rtl/core; depends on nothing
package befp_pkg;

	localparam int FRAME_SIZE_BITS = 16;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_BITS = $clog2(QUEUE_DEPTH);
	localparam int QCNT_BITS = $clog2(QUEUE_DEPTH + 1);

	localparam logic [3:0] PH_HDR     = 4'd0;
	localparam logic [3:0] PH_ERRCODE = 4'd1;
	localparam logic [3:0] PH_ERRLEN  = 4'd2;
	localparam logic [3:0] PH_SEQ     = 4'd3;
	localparam logic [3:0] PH_EVT     = 4'd4;
	localparam logic [3:0] PH_LEN1    = 4'd5;
	localparam logic [3:0] PH_ID      = 4'd6;
	localparam logic [3:0] PH_LEN2    = 4'd7;
	localparam logic [3:0] PH_PAY     = 4'd8;
	localparam logic [3:0] PH_DONE    = 4'd9;

	localparam logic [2:0] ST_OK         = 3'd0;
	localparam logic [2:0] ST_SHORT      = 3'd1;
	localparam logic [2:0] ST_BAD_HDR    = 3'd2;
	localparam logic [2:0] ST_NO_ERRC    = 3'd3;
	localparam logic [2:0] ST_BAD_ERRLEN = 3'd4;
	localparam logic [2:0] ST_NO_SEQ     = 3'd5;
	localparam logic [2:0] ST_NO_EVT     = 3'd6;
	localparam logic [2:0] ST_BAD_LEN    = 3'd7;

	localparam logic [1:0] KIND_ID  = 2'd0;
	localparam logic [1:0] KIND_PAY = 2'd1;
	localparam logic [1:0] KIND_SUM = 2'd2;

	localparam logic [3:0] VERSION_ONE     = 4'd1;
	localparam logic [3:0] ERR_TYPE_RESET  = 4'hf;
	localparam logic [5:0] MIN_HDR_BYTES   = 6'd4;
	localparam int         MIN_FRAME_BYTES = 8;
	localparam int         WORD_BYTES      = 4;

	localparam logic [31:0] EV_CONN_A = 32'd1;
	localparam logic [31:0] EV_CONN_B = 32'd2;
	localparam logic [31:0] EV_CONN_C = 32'd50;
	localparam logic [31:0] EV_CONN_D = 32'd51;
	localparam logic [31:0] EV_CONN_E = 32'd52;

	typedef struct packed {
		logic [7:0]                 data_byte;
		logic [FRAME_SIZE_BITS-1:0] frame_size;
	} in_item_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         out_byte;
		logic               last_of_frame;
		logic [2:0]         status;
		logic [3:0]         msg_type;
		logic [3:0]         flag_bits;
		logic [3:0]         serialization;
		logic [3:0]         compression;
		logic signed [31:0] sequence_res;
		logic [31:0]        event_code;
		logic [31:0]        error_number;
		logic               id_is_connection;
	} out_item_t;

	typedef struct packed {
		logic [1:0] count;
		out_item_t  first;
		out_item_t  second;
	} push_t;

endpackage

/* rtl/core/binary_event_frame_parser.sv */
// binary_event_frame_parser: top level of the streaming binary event frame parser
// depends on befp_pkg, befp_parser and befp_out_queue
// path: a byte passes the input register, then its results are written into the result queue and leave from it
// the frame summary is queued together with the closing byte's own result and leaves directly behind it
// throughput: one byte per cycle while the 4-entry result queue, draining one a cycle, has room for two results
// reset: arst_n clears parse state, queue and error type (to 15) at once; no clearing pass
module binary_event_frame_parser (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_ready,
	input  befp_pkg::in_item_t   item,
	output logic                 result_valid,
	input  logic                 result_ready,
	output befp_pkg::out_item_t  result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [3:0]           cfg_data
);

	befp_pkg::push_t push;
	logic            room;

	assign cfg_ready = 1'b1;

	befp_parser u_parser (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.cfg_valid  (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.room       (room),
		.push       (push)
	);

	befp_out_queue u_queue (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.room         (room),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

/* rtl/core/befp_parser.sv */
// befp_parser: input register, frame parse state and per-byte result logic
// depends on befp_pkg
module befp_parser (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  befp_pkg::in_item_t  item,
	input  logic                cfg_valid,
	input  logic [3:0]          cfg_data,
	input  logic                room,
	output befp_pkg::push_t     push
);

	typedef struct packed {
		logic [3:0]  phase;
		logic [5:0]  hdr_len;
		logic [15:0] nibbles;
		logic [31:0] wacc;
		logic [31:0] rc;
		logic [31:0] seq;
		logic [31:0] evt;
		logic [31:0] errc;
		logic [2:0]  status;
	} pstate_t;

	localparam pstate_t CLEAR_STATE = '{phase: befp_pkg::PH_HDR, status: befp_pkg::ST_OK,
		default: '0};

	function automatic pstate_t fail(pstate_t s, logic [2:0] code);
		pstate_t r;
		r = s;
		r.status = code;
		r.phase = befp_pkg::PH_DONE;
		return r;
	endfunction

	function automatic pstate_t enter_word(pstate_t s, logic [3:0] ph, logic [33:0] nx,
			logic [33:0] sz, logic [2:0] err);
		pstate_t r;
		r = s;
		if (nx + 34'(befp_pkg::WORD_BYTES) > sz) begin
			r = fail(s, err);
		end else begin
			r.phase = ph;
			r.rc = 32'(befp_pkg::WORD_BYTES);
			r.wacc = '0;
		end
		return r;
	endfunction

	function automatic pstate_t enter_payload(pstate_t s, logic [31:0] len);
		pstate_t r;
		r = s;
		if (len == '0) begin
			r.phase = befp_pkg::PH_DONE;
		end else begin
			r.phase = befp_pkg::PH_PAY;
			r.rc = len;
		end
		return r;
	endfunction

	function automatic pstate_t after_header(pstate_t s, logic [3:0] etc, logic [33:0] nx,
			logic [33:0] sz);
		pstate_t r;
		if (s.nibbles[15:12] == etc) begin
			r = enter_word(s, befp_pkg::PH_ERRCODE, nx, sz, befp_pkg::ST_NO_ERRC);
		end else if (s.nibbles[8]) begin
			r = enter_word(s, befp_pkg::PH_SEQ, nx, sz, befp_pkg::ST_NO_SEQ);
		end else if (s.nibbles[10]) begin
			r = enter_word(s, befp_pkg::PH_EVT, nx, sz, befp_pkg::ST_NO_EVT);
		end else begin
			r = enter_word(s, befp_pkg::PH_LEN1, nx, sz, befp_pkg::ST_BAD_LEN);
		end
		return r;
	endfunction

	function automatic pstate_t word_done(pstate_t s, logic [33:0] nx, logic [33:0] sz);
		pstate_t     r;
		logic [33:0] w;
		r = s;
		w = 34'(s.wacc);
		case (s.phase)
			befp_pkg::PH_ERRCODE: begin
				r.errc = s.wacc;
				r = enter_word(r, befp_pkg::PH_ERRLEN, nx, sz, befp_pkg::ST_BAD_ERRLEN);
			end
			befp_pkg::PH_ERRLEN: begin
				if (nx + w > sz) r = fail(r, befp_pkg::ST_BAD_ERRLEN);
				else r = enter_payload(r, s.wacc);
			end
			befp_pkg::PH_SEQ: begin
				r.seq = s.wacc;
				if (s.nibbles[10]) r = enter_word(r, befp_pkg::PH_EVT, nx, sz, befp_pkg::ST_NO_EVT);
				else r = enter_word(r, befp_pkg::PH_LEN1, nx, sz, befp_pkg::ST_BAD_LEN);
			end
			befp_pkg::PH_EVT: begin
				r.evt = s.wacc;
				r = enter_word(r, befp_pkg::PH_LEN1, nx, sz, befp_pkg::ST_BAD_LEN);
			end
			befp_pkg::PH_LEN1: begin
				if (nx + w == sz) begin
					r = enter_payload(r, s.wacc);
				end else if (nx + w + 34'(befp_pkg::WORD_BYTES) > sz) begin
					r = fail(r, befp_pkg::ST_BAD_LEN);
				end else if (s.wacc == '0) begin
					r = enter_word(r, befp_pkg::PH_LEN2, nx, sz, befp_pkg::ST_BAD_LEN);
				end else begin
					r.phase = befp_pkg::PH_ID;
					r.rc = s.wacc;
				end
			end
			default: begin
				if (nx + w > sz) r = fail(r, befp_pkg::ST_BAD_LEN);
				else r = enter_payload(r, s.wacc);
			end
		endcase
		return r;
	endfunction

	logic                                 valid_s1;
	befp_pkg::in_item_t                   item_s1;
	logic                                 advance;
	logic [3:0]                           err_type_q;
	pstate_t                              st_q;
	pstate_t                              ns;
	logic [befp_pkg::FRAME_SIZE_BITS-1:0] pos_q;
	logic [befp_pkg::FRAME_SIZE_BITS:0]   next_pos;
	logic [33:0]                          nx;
	logic [33:0]                          sz;
	logic [7:0]                           b;
	logic                                 byte_v;
	logic [1:0]                           byte_kind;
	logic                                 frame_end;
	logic                                 zero_flds;
	befp_pkg::out_item_t                  byte_res;
	befp_pkg::out_item_t                  sum_res;

	assign item_ready = !valid_s1 || room;
	assign advance = valid_s1 && room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (item_valid && item_ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_type_q <= befp_pkg::ERR_TYPE_RESET;
		end else if (cfg_valid) begin
			err_type_q <= cfg_data;
		end
	end

	assign b = item_s1.data_byte;
	assign sz = 34'(item_s1.frame_size);
	assign next_pos = (befp_pkg::FRAME_SIZE_BITS + 1)'(pos_q) + 1'b1;
	assign nx = 34'(next_pos);
	assign frame_end = nx >= sz;

	always_comb begin
		ns = st_q;
		byte_v = 1'b0;
		byte_kind = befp_pkg::KIND_PAY;
		case (st_q.phase)
			befp_pkg::PH_HDR: begin
				if (pos_q == '0) begin
					ns.hdr_len = {b[3:0], 2'b00};
					if (sz < 34'(befp_pkg::MIN_FRAME_BYTES)) begin
						ns = fail(ns, befp_pkg::ST_SHORT);
					end else if (b[7:4] != befp_pkg::VERSION_ONE
							|| ns.hdr_len < befp_pkg::MIN_HDR_BYTES
							|| 34'(ns.hdr_len) > sz) begin
						ns = fail(ns, befp_pkg::ST_BAD_HDR);
					end
				end else begin
					if (pos_q == befp_pkg::FRAME_SIZE_BITS'(1)) ns.nibbles[15:8] = b;
					else if (pos_q == befp_pkg::FRAME_SIZE_BITS'(2)) ns.nibbles[7:0] = b;
					if (nx >= 34'(ns.hdr_len)) ns = after_header(ns, err_type_q, nx, sz);
				end
			end
			befp_pkg::PH_ERRCODE, befp_pkg::PH_ERRLEN, befp_pkg::PH_SEQ,
			befp_pkg::PH_EVT, befp_pkg::PH_LEN1, befp_pkg::PH_LEN2: begin
				ns.wacc = {st_q.wacc[23:0], b};
				if (st_q.rc != '0) ns.rc = st_q.rc - 1'b1;
				if (ns.rc == '0) ns = word_done(ns, nx, sz);
			end
			befp_pkg::PH_ID, befp_pkg::PH_PAY: begin
				byte_v = 1'b1;
				byte_kind = (st_q.phase == befp_pkg::PH_ID) ? befp_pkg::KIND_ID
					: befp_pkg::KIND_PAY;
				if (st_q.rc != '0) ns.rc = st_q.rc - 1'b1;
				if (ns.rc == '0) begin
					if (st_q.phase == befp_pkg::PH_ID) begin
						ns = enter_word(ns, befp_pkg::PH_LEN2, nx, sz, befp_pkg::ST_BAD_LEN);
					end else begin
						ns.phase = befp_pkg::PH_DONE;
					end
				end
			end
			default: begin
			end
		endcase
		if (frame_end && ns.phase != befp_pkg::PH_DONE && ns.status == befp_pkg::ST_OK) begin
			ns.status = befp_pkg::ST_SHORT;
		end
	end

	assign zero_flds = ns.status == befp_pkg::ST_SHORT || ns.status == befp_pkg::ST_BAD_HDR;

	always_comb begin
		byte_res = '0;
		byte_res.kind = byte_kind;
		byte_res.out_byte = b;
		sum_res = '0;
		sum_res.kind = befp_pkg::KIND_SUM;
		sum_res.last_of_frame = 1'b1;
		sum_res.status = ns.status;
		if (!zero_flds) begin
			sum_res.msg_type = ns.nibbles[15:12];
			sum_res.flag_bits = ns.nibbles[11:8];
			sum_res.serialization = ns.nibbles[7:4];
			sum_res.compression = ns.nibbles[3:0];
			sum_res.sequence_res = $signed(ns.seq);
			sum_res.event_code = ns.evt;
			sum_res.error_number = ns.errc;
			sum_res.id_is_connection = ns.evt == befp_pkg::EV_CONN_A
				|| ns.evt == befp_pkg::EV_CONN_B || ns.evt == befp_pkg::EV_CONN_C
				|| ns.evt == befp_pkg::EV_CONN_D || ns.evt == befp_pkg::EV_CONN_E;
		end
	end

	always_comb begin
		push.count = '0;
		push.first = byte_v ? byte_res : sum_res;
		push.second = sum_res;
		if (advance) begin
			push.count = 2'(byte_v) + 2'(frame_end);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= CLEAR_STATE;
			pos_q <= '0;
		end else if (advance) begin
			if (frame_end) begin
				st_q <= CLEAR_STATE;
				pos_q <= '0;
			end else begin
				st_q <= ns;
				pos_q <= next_pos[befp_pkg::FRAME_SIZE_BITS-1:0];
			end
		end
	end

endmodule

/* rtl/core/befp_out_queue.sv */
// befp_out_queue: small result queue taking up to two results per cycle
// depends on befp_pkg
module befp_out_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  befp_pkg::push_t      push,
	output logic                 room,
	output logic                 result_valid,
	input  logic                 result_ready,
	output befp_pkg::out_item_t  result
);

	befp_pkg::out_item_t             mem_q [befp_pkg::QUEUE_DEPTH];
	logic [befp_pkg::QPTR_BITS-1:0]  wr_q;
	logic [befp_pkg::QPTR_BITS-1:0]  rd_q;
	logic [befp_pkg::QCNT_BITS-1:0]  cnt_q;
	logic [befp_pkg::QPTR_BITS-1:0]  wr_next;
	logic                            pop;

	assign room = cnt_q <= befp_pkg::QCNT_BITS'(befp_pkg::QUEUE_DEPTH - 2);
	assign result_valid = cnt_q != '0;
	assign result = mem_q[rd_q];
	assign pop = result_valid && result_ready;
	assign wr_next = wr_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_q <= wr_q + befp_pkg::QPTR_BITS'(push.count);
			if (pop) rd_q <= rd_q + 1'b1;
			cnt_q <= cnt_q + befp_pkg::QCNT_BITS'(push.count) - befp_pkg::QCNT_BITS'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push.count != '0) mem_q[wr_q] <= push.first;
		if (push.count == 2'd2) mem_q[wr_next] <= push.second;
	end

endmodule

/* rtl/core/befp_checker.sv */
// befp_checker: port-level assertions for binary_event_frame_parser, bound to the top
// depends on befp_pkg
module befp_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 result_valid,
	input logic                 result_ready,
	input befp_pkg::out_item_t  result
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last_of_frame == (result.kind == befp_pkg::KIND_SUM)))
		else $error("last_of_frame not on summary");

	a_byte_clean: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind != befp_pkg::KIND_SUM
			|-> result.status == befp_pkg::ST_OK && result.event_code == '0
			&& result.id_is_connection == 1'b0)
		else $error("byte transaction carries summary fields");

	a_bad_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == befp_pkg::KIND_SUM
			&& (result.status == befp_pkg::ST_SHORT || result.status == befp_pkg::ST_BAD_HDR)
			|-> result.msg_type == '0 && result.flag_bits == '0 && result.sequence_res == '0
			&& result.event_code == '0 && result.error_number == '0)
		else $error("header failure summary not cleared");

	a_conn_event: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.id_is_connection
			|-> result.event_code == befp_pkg::EV_CONN_A
			|| result.event_code == befp_pkg::EV_CONN_B
			|| result.event_code == befp_pkg::EV_CONN_C
			|| result.event_code == befp_pkg::EV_CONN_D
			|| result.event_code == befp_pkg::EV_CONN_E)
		else $error("connection flag with other event");

endmodule

bind binary_event_frame_parser befp_checker u_befp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.result_valid (result_valid),
	.result_ready (result_ready),
	.result       (result)
);
